[design/ipds_pkg.sv]
// Shared types, codes and palette for the indexed pixel display streamer.
package ipds_pkg;

    localparam int PIXELS_PER_WORD_DEF = 8;
    localparam int NIBBLES_PER_WORD    = 8;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;

    localparam logic [3:0] STEP_COL_CMD = 4'd0;
    localparam logic [3:0] STEP_COL_XH  = 4'd1;
    localparam logic [3:0] STEP_COL_XL  = 4'd2;
    localparam logic [3:0] STEP_COL_EH  = 4'd3;
    localparam logic [3:0] STEP_COL_EL  = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD = 4'd5;
    localparam logic [3:0] STEP_ROW_YH  = 4'd6;
    localparam logic [3:0] STEP_ROW_YL  = 4'd7;
    localparam logic [3:0] STEP_ROW_EH  = 4'd8;
    localparam logic [3:0] STEP_ROW_EL  = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD = 4'd10;

    typedef struct packed {
        logic        kind;
        logic [7:0]  x;
        logic [7:0]  x_end;
        logic [7:0]  y;
        logic [7:0]  y_end;
        logic [31:0] pix;
        logic [3:0]  count;
    } t_item;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    function automatic logic [15:0] palette(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'hFFFF;
            4'd1:    c = 16'h0000;
            4'd2:    c = 16'hF800;
            4'd3:    c = 16'h07E0;
            4'd4:    c = 16'h04C5;
            4'd5:    c = 16'h03E0;
            4'd6:    c = 16'h001F;
            4'd7:    c = 16'h7BEF;
            4'd8:    c = 16'h39E7;
            4'd9:    c = 16'h18C3;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

[design/indexed_pixel_display_streamer.sv]
// Top level: front end, item queue and word sequencer of the display streamer.
// An item passes through the queue and the sequencer's item register before its first word reaches the output register.
// Throughput: one word per cycle from the output register while i_stall is low; a window item
// produces eleven words and a pixel item as many words as its saturated pixel count.
// Pixel items with a zero count are accepted and produce no words.
// Reset (synchronous, active low) empties the queue and the output register at once.
module indexed_pixel_display_streamer #(
    parameter int PIXELS_PER_WORD = ipds_pkg::PIXELS_PER_WORD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_win_x,
    input  logic [7:0]  i_win_y,
    input  logic [8:0]  i_win_width,
    input  logic [8:0]  i_win_height,
    input  logic [31:0] i_pixel_word,
    input  logic [3:0]  i_pixel_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_word,
    output logic        o_is_data,
    output logic        o_wide_word,
    output logic        o_last
);
    import ipds_pkg::*;

    logic  push, full, q_valid, q_pop;
    t_item f_item, q_item;

    assign o_stall = full;

    ipds_front #(
        .PIXELS_PER_WORD(PIXELS_PER_WORD)
    ) u_front (
        .i_valid       (i_valid),
        .i_command     (i_command),
        .i_win_x       (i_win_x),
        .i_win_y       (i_win_y),
        .i_win_width   (i_win_width),
        .i_win_height  (i_win_height),
        .i_pixel_word  (i_pixel_word),
        .i_pixel_count (i_pixel_count),
        .i_full        (full),
        .o_push        (push),
        .o_item        (f_item)
    );

    ipds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    ipds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_word  (o_out_word),
        .o_is_data   (o_is_data),
        .o_wide_word (o_wide_word),
        .o_last      (o_last)
    );

endmodule

[design/ipds_front.sv]
// Front end: classify input words, precompute window bytes, saturate pixel counts.
module ipds_front #(
    parameter int PIXELS_PER_WORD = ipds_pkg::PIXELS_PER_WORD_DEF
) (
    input  logic                i_valid,
    input  logic                i_command,
    input  logic [7:0]          i_win_x,
    input  logic [7:0]          i_win_y,
    input  logic [8:0]          i_win_width,
    input  logic [8:0]          i_win_height,
    input  logic [31:0]         i_pixel_word,
    input  logic [3:0]          i_pixel_count,
    input  logic                i_full,
    output logic                o_push,
    output ipds_pkg::t_item     o_item
);
    import ipds_pkg::*;

    localparam int LIMIT = (PIXELS_PER_WORD < NIBBLES_PER_WORD) ?
                           PIXELS_PER_WORD : NIBBLES_PER_WORD;

    logic [3:0] sat_count;

    always_comb begin
        sat_count = (i_pixel_count > 4'(LIMIT)) ? 4'(LIMIT) : i_pixel_count;
        o_item.kind  = i_command;
        o_item.x     = i_win_x;
        o_item.y     = i_win_y;
        o_item.x_end = i_win_x + i_win_width[7:0] - 8'd1;
        o_item.y_end = i_win_y + i_win_height[7:0] - 8'd1;
        o_item.pix   = i_pixel_word;
        o_item.count = sat_count;
    end

    // drop pixel words with nothing to emit
    assign o_push = i_valid && !i_full &&
                    ((i_command == KIND_WINDOW) || (sat_count != 4'd0));

endmodule

[design/ipds_queue.sv]
// Short queue between the front end and the word sequencer.
module ipds_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ipds_pkg::t_item     i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output ipds_pkg::t_item     o_item
);
    import ipds_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[design/ipds_back.sv]
// Back end: sequence queued items into display words through an output register.
module ipds_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ipds_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [15:0]         o_out_word,
    output logic                o_is_data,
    output logic                o_wide_word,
    output logic                o_last
);
    import ipds_pkg::*;

    t_back_state r_state, n_state;
    t_item       r_item;
    logic [3:0]  r_step;
    logic [31:0] r_pix;
    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic        r_is_data, r_wide_word, r_last;

    logic        out_ready, emit, step_last;
    logic [15:0] w_word;
    logic        w_data, w_wide;

    assign out_ready = !r_out_valid || !i_stall;

    always_comb begin
        if (r_item.kind == KIND_PIXEL) begin
            step_last = (r_step == r_item.count - 4'd1);
        end else begin
            step_last = (r_step == STEP_MEM_CMD);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (out_ready && step_last && !i_q_valid) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        emit    = 1'b0;
        o_q_pop = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_q_pop = i_q_valid;
            end
            BK_RUN: begin
                emit    = out_ready;
                o_q_pop = out_ready && step_last && i_q_valid;
            end
            default: begin
                emit    = 1'b0;
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_data = 1'b1;
        w_wide = 1'b0;
        w_word = 16'h0000;
        if (r_item.kind == KIND_PIXEL) begin
            w_wide = 1'b1;
            w_word = palette(r_pix[3:0]);
        end else begin
            case (r_step)
                STEP_COL_CMD: begin
                    w_word = {8'h00, CMD_COLUMN_SET};
                    w_data = 1'b0;
                end
                STEP_COL_XL: w_word = {8'h00, r_item.x};
                STEP_COL_EL: w_word = {8'h00, r_item.x_end};
                STEP_ROW_CMD: begin
                    w_word = {8'h00, CMD_ROW_SET};
                    w_data = 1'b0;
                end
                STEP_ROW_YL: w_word = {8'h00, r_item.y};
                STEP_ROW_EL: w_word = {8'h00, r_item.y_end};
                STEP_MEM_CMD: begin
                    w_word = {8'h00, CMD_MEM_WRITE};
                    w_data = 1'b0;
                end
                STEP_COL_XH, STEP_COL_EH, STEP_ROW_YH, STEP_ROW_EH: begin
                    w_word = {8'h00, BYTE_ZERO};
                end
                default: w_word = {8'h00, BYTE_ZERO};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_step <= '0;
            end else if (emit) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_pix  <= i_q_item.pix;
        end else if (emit) begin
            r_pix  <= {4'h0, r_pix[31:4]};
        end
        if (emit) begin
            r_out_word  <= w_word;
            r_is_data   <= w_data;
            r_wide_word <= w_wide;
            r_last      <= step_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_is_data   = r_is_data;
    assign o_wide_word = r_wide_word;
    assign o_last      = r_last;

endmodule

[tb/tb_top.sv]
// Testbench for the indexed pixel display streamer: directed and random traffic, self-checking predictor.
`timescale 1ns / 100ps

module tb_top;

    import ipds_pkg::*;

    localparam int PPW        = PIXELS_PER_WORD_DEF;
    localparam int NIB_LIMIT  = (PPW < 8) ? PPW : 8;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_WAIT  = 10;
    localparam int N_RANDOM   = 94;

    typedef struct {
        logic        command;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [31:0] pix;
        logic [3:0]  cnt;
        bit          drain_first;
    } disp_req_t;

    typedef struct {
        logic [15:0] word;
        logic        is_data;
        logic        wide;
        logic        last;
    } lcd_word_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic        i_command     = 1'b0;
    logic [7:0]  i_win_x       = '0;
    logic [7:0]  i_win_y       = '0;
    logic [8:0]  i_win_width   = '0;
    logic [8:0]  i_win_height  = '0;
    logic [31:0] i_pixel_word  = '0;
    logic [3:0]  i_pixel_count = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [15:0] o_out_word;
    logic        o_is_data;
    logic        o_wide_word;
    logic        o_last;

    disp_req_t pending_reqs[$];
    lcd_word_t lcd_expected[$];

    int n_fail      = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit calm_tx     = 1'b0;
    bit calm_rx     = 1'b0;
    bit timed_out   = 1'b0;

    indexed_pixel_display_streamer #(
        .PIXELS_PER_WORD(PPW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_win_x       (i_win_x),
        .i_win_y       (i_win_y),
        .i_win_width   (i_win_width),
        .i_win_height  (i_win_height),
        .i_pixel_word  (i_pixel_word),
        .i_pixel_count (i_pixel_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_word    (o_out_word),
        .o_is_data     (o_is_data),
        .o_wide_word   (o_wide_word),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] rgb565(input int r, input int g, input int b);
        logic [15:0] c;
        c = {5'(r), 6'(g), 5'(b)};
        return c;
    endfunction

    function automatic logic [15:0] palette_color(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'hFFFF;
            4'd1:    c = 16'h0000;
            4'd2:    c = rgb565(31, 0, 0);
            4'd3:    c = rgb565(0, 63, 0);
            4'd4:    c = rgb565(0, 38, 5);
            4'd5:    c = rgb565(0, 31, 0);
            4'd6:    c = rgb565(0, 0, 31);
            4'd7:    c = rgb565(15, 31, 15);
            4'd8:    c = rgb565(7, 15, 7);
            4'd9:    c = rgb565(3, 6, 3);
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    task automatic push_word(input logic [15:0] word, input logic is_data,
                             input logic wide, input logic last);
        lcd_word_t e;
        e.word    = word;
        e.is_data = is_data;
        e.wide    = wide;
        e.last    = last;
        lcd_expected.push_back(e);
    endtask

    task automatic predict_lcd_words(input disp_req_t r);
        logic [7:0] x_end;
        logic [7:0] y_end;
        int         n;
        if (r.command == KIND_WINDOW) begin
            x_end = 8'(r.x + r.w - 1);
            y_end = 8'(r.y + r.h - 1);
            push_word({8'h00, CMD_COLUMN_SET}, 1'b0, 1'b0, 1'b0);
            push_word({8'h00, BYTE_ZERO},      1'b1, 1'b0, 1'b0);
            push_word({8'h00, r.x},            1'b1, 1'b0, 1'b0);
            push_word({8'h00, BYTE_ZERO},      1'b1, 1'b0, 1'b0);
            push_word({8'h00, x_end},          1'b1, 1'b0, 1'b0);
            push_word({8'h00, CMD_ROW_SET},    1'b0, 1'b0, 1'b0);
            push_word({8'h00, BYTE_ZERO},      1'b1, 1'b0, 1'b0);
            push_word({8'h00, r.y},            1'b1, 1'b0, 1'b0);
            push_word({8'h00, BYTE_ZERO},      1'b1, 1'b0, 1'b0);
            push_word({8'h00, y_end},          1'b1, 1'b0, 1'b0);
            push_word({8'h00, CMD_MEM_WRITE},  1'b0, 1'b0, 1'b1);
        end else begin
            n = (int'(r.cnt) > NIB_LIMIT) ? NIB_LIMIT : int'(r.cnt);
            for (int i = 0; i < n; i++) begin
                push_word(palette_color(r.pix[4*i +: 4]), 1'b1, 1'b1, (i + 1 == n));
            end
        end
    endtask

    function automatic int pick_pause(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic disp_req_t mk_window(input logic [7:0] x, input logic [7:0] y,
                                            input logic [8:0] w, input logic [8:0] h,
                                            input bit drain);
        disp_req_t r;
        r.command     = KIND_WINDOW;
        r.x           = x;
        r.y           = y;
        r.w           = w;
        r.h           = h;
        r.pix         = $urandom;
        r.cnt         = 4'($urandom_range(0, 15));
        r.drain_first = drain;
        return r;
    endfunction

    function automatic disp_req_t mk_pixels(input logic [31:0] pix, input logic [3:0] cnt,
                                            input bit drain);
        disp_req_t r;
        r.command     = KIND_PIXEL;
        r.x           = 8'($urandom);
        r.y           = 8'($urandom);
        r.w           = 9'($urandom);
        r.h           = 9'($urandom);
        r.pix         = pix;
        r.cnt         = cnt;
        r.drain_first = drain;
        return r;
    endfunction

    always @(posedge i_clk) begin : drive
        disp_req_t r;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                r.command = i_command;
                r.x       = i_win_x;
                r.y       = i_win_y;
                r.w       = i_win_width;
                r.h       = i_win_height;
                r.pix     = i_pixel_word;
                r.cnt     = i_pixel_count;
                predict_lcd_words(r);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain_first && lcd_expected.size() != 0)) begin
                    r = pending_reqs.pop_front();
                    i_valid       <= 1'b1;
                    i_command     <= r.command;
                    i_win_x       <= r.x;
                    i_win_y       <= r.y;
                    i_win_width   <= r.w;
                    i_win_height  <= r.h;
                    i_pixel_word  <= r.pix;
                    i_pixel_count <= r.cnt;
                    gap_left      <= pick_pause(calm_tx);
                    if ($urandom_range(0, 19) == 0) calm_tx <= !calm_tx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        lcd_word_t e;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (lcd_expected.size() == 0) begin
                    $error("unexpected word: out_word actual %h", o_out_word);
                    n_fail++;
                end else begin
                    e = lcd_expected.pop_front();
                    if (o_out_word !== e.word) begin
                        $error("out_word: expected %h actual %h", e.word, o_out_word);
                        n_fail++;
                    end
                    if (o_is_data !== e.is_data) begin
                        $error("is_data: expected %b actual %b", e.is_data, o_is_data);
                        n_fail++;
                    end
                    if (o_wide_word !== e.wide) begin
                        $error("wide_word: expected %b actual %b", e.wide, o_wide_word);
                        n_fail++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %b actual %b", e.last, o_last);
                        n_fail++;
                    end
                end
                if ($urandom_range(0, 39) == 0) calm_rx <= !calm_rx;
            end
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) stall_left <= pick_pause(calm_rx);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : main
        logic [8:0] w;
        logic [8:0] h;
        logic [3:0] cnt;
        int         sel;

        pending_reqs.push_back(mk_window(8'd0, 8'd0, 9'd1, 9'd1, 1'b0));
        pending_reqs.push_back(mk_window(8'd255, 8'd255, 9'd256, 9'd256, 1'b0));
        pending_reqs.push_back(mk_window(8'd0, 8'd0, 9'd0, 9'd0, 1'b0));
        pending_reqs.push_back(mk_window(8'd128, 8'd77, 9'd511, 9'd511, 1'b0));
        pending_reqs.push_back(mk_window(8'd10, 8'd20, 9'd300, 9'd1, 1'b0));
        pending_reqs.push_back(mk_pixels(32'h7654_3210, 4'd8, 1'b1));
        pending_reqs.push_back(mk_pixels(32'hFEDC_BA98, 4'd8, 1'b0));
        pending_reqs.push_back(mk_pixels(32'hFFFF_FFFF, 4'd0, 1'b0));
        pending_reqs.push_back(mk_pixels(32'h0000_0000, 4'd15, 1'b0));
        pending_reqs.push_back(mk_pixels($urandom, 4'd9, 1'b0));
        pending_reqs.push_back(mk_pixels(32'h0000_000F, 4'd1, 1'b0));
        pending_reqs.push_back(mk_pixels(32'h0000_0009, 4'd1, 1'b0));
        pending_reqs.push_back(mk_pixels(32'h3210_9876, 4'd7, 1'b0));
        pending_reqs.push_back(mk_pixels(32'hFFFF_FFFF, 4'd8, 1'b0));
        pending_reqs.push_back(mk_window(8'd1, 8'd254, 9'd2, 9'd3, 1'b1));
        pending_reqs.push_back(mk_pixels(32'h89AB_CDEF, 4'd2, 1'b0));

        for (int k = 0; k < N_RANDOM; k++) begin
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
                w = ($urandom_range(0, 9) == 0) ?
                    (($urandom_range(0, 1) == 1) ? 9'd0 : 9'($urandom_range(257, 511))) :
                    9'($urandom_range(1, 256));
                h = ($urandom_range(0, 9) == 0) ?
                    (($urandom_range(0, 1) == 1) ? 9'd0 : 9'($urandom_range(257, 511))) :
                    9'($urandom_range(1, 256));
                pending_reqs.push_back(mk_window(8'($urandom), 8'($urandom), w, h,
                                                 $urandom_range(0, 39) == 0));
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    cnt = 4'd0;
                else if (sel < 3)
                    cnt = 4'($urandom_range(9, 15));
                else
                    cnt = 4'($urandom_range(1, 8));
                pending_reqs.push_back(mk_pixels($urandom, cnt, $urandom_range(0, 39) == 0));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out &&
               !(pending_reqs.size() == 0 && !i_valid && lcd_expected.size() == 0)) begin
            @(negedge i_clk);
            if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
        end
        if (!timed_out) repeat (TAIL_WAIT) @(negedge i_clk);

        if (timed_out) begin
            $display("[indexed_pixel_display_streamer] ERROR");
        end else if (n_fail == 0) begin
            $display("[indexed_pixel_display_streamer] OK");
        end else begin
            $display("[indexed_pixel_display_streamer] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
design/ipds_pkg.sv
design/ipds_front.sv
design/ipds_queue.sv
design/ipds_back.sv
design/indexed_pixel_display_streamer.sv
tb/tb_top.sv
